// ----- src/capability_table_engine_top_macros.svh -----
// Assertion macros for the capability table engine.
`ifndef CAPABILITY_TABLE_ENGINE_TOP_MACROS_SVH
`define CAPABILITY_TABLE_ENGINE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define CTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/cte_pkg.sv -----
// Types and codes shared by the capability table engine modules.
package cte_pkg;

  localparam int unsigned KIND_W   = 16;
  localparam int unsigned RIGHTS_W = 32;
  localparam int unsigned OBJ_W    = 64;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned SLOTO_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REVOKE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DERIVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [RIGHTS_W-1:0] rights;
    logic [OBJ_W-1:0]    object;
  } entry_t;

endpackage

// ----- src/capability_table_engine_top.sv -----
// Capability table engine: slot table in RAM with command sequencer.
//
// Channel  Ports                                   Transfer
// input    in_command in_slot in_entry_type ...    start high while busy low
// result   out_status out_slot_out out_object_out  out_valid high, one cycle
//
// Each command reads its slot from the table RAM in the accept cycle; in the
// next it is checked, and a successful INSERT or DERIVE writes the encoded lowest free slot.
// The result appears in the cycle after that; a new command may be accepted then.
// Reset clears the occupancy bits; the RAM needs no clearing.
// The receiver cannot stall; busy blocks start only during the execute cycle.
`include "capability_table_engine_top_macros.svh"

module capability_table_engine_top #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [cte_pkg::CMD_W-1:0]         in_command,
  input  logic [cte_pkg::SLOT_W-1:0]        in_slot,
  input  logic [cte_pkg::KIND_W-1:0]        in_entry_type,
  input  logic [cte_pkg::RIGHTS_W-1:0]      in_rights,
  input  logic [cte_pkg::OBJ_W-1:0]         in_object_handle,
  output logic                              out_valid,
  output logic [cte_pkg::STATUS_W-1:0]      out_status,
  output logic [cte_pkg::SLOTO_W-1:0]       out_slot_out,
  output logic [cte_pkg::OBJ_W-1:0]         out_object_out
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                            state_r, state_nxt;
  logic [NUM_SLOTS-1:0]            used_r, used_nxt;
  logic [cte_pkg::CMD_W-1:0]       cmd_r;
  logic [cte_pkg::SLOT_W-1:0]      slot_r;
  logic [cte_pkg::KIND_W-1:0]      kind_r;
  logic [cte_pkg::RIGHTS_W-1:0]    rights_r;
  logic [cte_pkg::OBJ_W-1:0]       obj_r;
  logic                            inrange_r;
  logic                            out_valid_r;
  logic [cte_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [cte_pkg::SLOTO_W-1:0]     out_slot_r, out_slot_nxt;
  logic [cte_pkg::OBJ_W-1:0]       out_object_r, out_object_nxt;

  logic                            accept;
  logic                            in_inrange;
  logic                            we;
  cte_pkg::entry_t                 wdata;
  cte_pkg::entry_t                 rd_entry;
  logic [AW-1:0]                   free_idx_r;
  logic                            full_r;
  logic                            slot_used;

  assign busy       = state_r;
  assign accept     = start && !busy;
  assign in_inrange = ({1'b0, in_slot} < 9'(NUM_SLOTS));

  cte_ram #(
    .WIDTH ($bits(cte_pkg::entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (free_idx_r),
    .wdata   (wdata),
    .re      (accept && in_inrange),
    .raddr   (in_slot[AW-1:0]),
    .rdata_r (rd_entry)
  );

  cte_free_enc #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_free (
    .clk        (clk),
    .used       (used_r),
    .free_idx_r (free_idx_r),
    .full_r     (full_r)
  );

  assign slot_used = used_r[slot_r[AW-1:0]];

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    we             = 1'b0;
    wdata          = '{kind: kind_r, rights: rights_r, object: obj_r};
    out_status_nxt = cte_pkg::ST_OK;
    out_slot_nxt   = '0;
    out_object_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        priority if (cmd_r == cte_pkg::CMD_INSERT) begin
          if (full_r) begin
            out_status_nxt = cte_pkg::ST_FULL;
          end else begin
            we                   = 1'b1;
            used_nxt[free_idx_r] = (kind_r != '0);
            out_slot_nxt         = cte_pkg::SLOTO_W'(free_idx_r);
          end
        end else if (!inrange_r) begin
          out_status_nxt = cte_pkg::ST_INVALID;
        end else if (!slot_used) begin
          out_status_nxt = cte_pkg::ST_FREE;
        end else if (cmd_r == cte_pkg::CMD_LOOKUP) begin
          if ((rd_entry.rights & rights_r) != rights_r) begin
            out_status_nxt = cte_pkg::ST_DENIED;
          end else begin
            out_object_nxt = rd_entry.object;
          end
        end else if (cmd_r == cte_pkg::CMD_REVOKE) begin
          used_nxt[slot_r[AW-1:0]] = 1'b0;
        end else begin
          wdata = '{kind: rd_entry.kind, rights: rights_r, object: rd_entry.object};
          if ((rd_entry.rights & rights_r) != rights_r) begin
            out_status_nxt = cte_pkg::ST_DENIED;
          end else if (full_r) begin
            out_status_nxt = cte_pkg::ST_FULL;
          end else begin
            we                   = 1'b1;
            used_nxt[free_idx_r] = 1'b1;
            out_slot_nxt         = cte_pkg::SLOTO_W'(free_idx_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      slot_r    <= in_slot;
      kind_r    <= in_entry_type;
      rights_r  <= in_rights;
      obj_r     <= in_object_handle;
      inrange_r <= in_inrange;
    end
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_object_r <= out_object_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_object_out = out_object_r;

  `CTE_ASSERT_NEXT(a_result_follows, accept, ##1 out_valid)
  `CTE_ASSERT_NOW(a_strobe_when_idle, out_valid, !busy)
  `CTE_ASSERT_NEXT(a_busy_one_cycle, busy, !busy)
  `CTE_ASSERT_NOW(a_fail_zero_payload, out_valid && (out_status != cte_pkg::ST_OK),
                  (out_object_out == '0) && (out_slot_out == '0))

endmodule

// ----- src/cte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/cte_free_enc.sv -----
// Registered lowest-free-slot encoder over the slot occupancy vector.
module cte_free_enc #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                         clk,
  input  logic [NUM_SLOTS-1:0]         used,
  output logic [$clog2(NUM_SLOTS)-1:0] free_idx_r,
  output logic                         full_r
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);

  logic [AW-1:0] free_idx_nxt;
  logic          full_nxt;

  always_comb begin
    free_idx_nxt = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx_nxt = AW'(i);
      end
    end
    full_nxt = &used;
  end

  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    full_r     <= full_nxt;
  end

endmodule

// ----- sim/tb_capability_table_engine_top.sv -----
// Self-checking testbench for the capability table engine: directed table plus random traffic.
module tb_capability_table_engine_top;

  localparam int NUM_SLOTS     = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_SEGMENTS = 10;
  localparam int SEGMENT_ITEMS = 145;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct {
    logic [cte_pkg::CMD_W-1:0]    command;
    logic [cte_pkg::SLOT_W-1:0]   slot;
    logic [cte_pkg::KIND_W-1:0]   kind;
    logic [cte_pkg::RIGHTS_W-1:0] rights;
    logic [cte_pkg::OBJ_W-1:0]    obj;
  } cap_cmd_t;

  typedef struct {
    logic [cte_pkg::STATUS_W-1:0] status;
    logic [cte_pkg::SLOTO_W-1:0]  slot;
    logic [cte_pkg::OBJ_W-1:0]    obj;
  } cap_result_t;

  typedef struct {
    cap_cmd_t    cmd;
    bit          fixed;
    cap_result_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [cte_pkg::CMD_W-1:0]    in_command;
  logic [cte_pkg::SLOT_W-1:0]   in_slot;
  logic [cte_pkg::KIND_W-1:0]   in_entry_type;
  logic [cte_pkg::RIGHTS_W-1:0] in_rights;
  logic [cte_pkg::OBJ_W-1:0]    in_object_handle;
  logic                         out_valid;
  logic [cte_pkg::STATUS_W-1:0] out_status;
  logic [cte_pkg::SLOTO_W-1:0]  out_slot_out;
  logic [cte_pkg::OBJ_W-1:0]    out_object_out;

  logic [cte_pkg::KIND_W-1:0]   kind_tbl   [NUM_SLOTS];
  logic [cte_pkg::RIGHTS_W-1:0] rights_tbl [NUM_SLOTS];
  logic [cte_pkg::OBJ_W-1:0]    obj_tbl    [NUM_SLOTS];

  cap_result_t pending_results[$];
  dir_row_t    dir_rows[$];
  bit          row_fixed;
  cap_result_t row_want;

  int error_count;
  int cycle_count;
  int accepted_count;
  int result_count;
  int status_seen[5];

  capability_table_engine_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_slot(in_slot),
    .in_entry_type(in_entry_type),
    .in_rights(in_rights),
    .in_object_handle(in_object_handle),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slot_out(out_slot_out),
    .out_object_out(out_object_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int lowest_free_slot();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (kind_tbl[i] == '0) return i;
    end
    return -1;
  endfunction

  function automatic cap_result_t apply_cap_command(cap_cmd_t c);
    cap_result_t r;
    int dst;
    int s;
    r.status = cte_pkg::ST_OK;
    r.slot   = '0;
    r.obj    = '0;
    s = int'(c.slot);
    if (c.command == cte_pkg::CMD_INSERT) begin
      dst = lowest_free_slot();
      if (dst < 0) begin
        r.status = cte_pkg::ST_FULL;
      end else begin
        kind_tbl[dst]   = c.kind;
        rights_tbl[dst] = c.rights;
        obj_tbl[dst]    = c.obj;
        r.slot          = cte_pkg::SLOTO_W'(dst);
      end
    end else if (s >= NUM_SLOTS) begin
      r.status = cte_pkg::ST_INVALID;
    end else if (kind_tbl[s] == '0) begin
      r.status = cte_pkg::ST_FREE;
    end else if (c.command == cte_pkg::CMD_LOOKUP) begin
      if ((rights_tbl[s] & c.rights) != c.rights) r.status = cte_pkg::ST_DENIED;
      else r.obj = obj_tbl[s];
    end else if (c.command == cte_pkg::CMD_REVOKE) begin
      kind_tbl[s]   = '0;
      rights_tbl[s] = '0;
      obj_tbl[s]    = '0;
    end else begin
      if ((c.rights & rights_tbl[s]) != c.rights) begin
        r.status = cte_pkg::ST_DENIED;
      end else begin
        dst = lowest_free_slot();
        if (dst < 0) begin
          r.status = cte_pkg::ST_FULL;
        end else begin
          kind_tbl[dst]   = kind_tbl[s];
          rights_tbl[dst] = c.rights;
          obj_tbl[dst]    = obj_tbl[s];
          r.slot          = cte_pkg::SLOTO_W'(dst);
        end
      end
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    $display("ERROR @%0d result %0d: %s", cycle_count, result_count, msg);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_capability_table_engine_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    cap_result_t want;
    cap_result_t pred;
    cap_cmd_t    c;
    if (rst_n) begin
      if (out_valid) begin
        result_count++;
        if (pending_results.size() == 0) begin
          flag_error("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_slot_out !== want.slot)
            flag_error($sformatf("slot_out got %0d want %0d", out_slot_out, want.slot));
          if (out_object_out !== want.obj)
            flag_error($sformatf("object_out got %h want %h", out_object_out, want.obj));
          if (want.status <= cte_pkg::ST_DENIED) status_seen[want.status]++;
        end
      end
      if (start && !busy) begin
        accepted_count++;
        c.command = in_command;
        c.slot    = in_slot;
        c.kind    = in_entry_type;
        c.rights  = in_rights;
        c.obj     = in_object_handle;
        pred = apply_cap_command(c);
        if (row_fixed) pending_results.push_back(row_want);
        else pending_results.push_back(pred);
      end
    end
  end

  task automatic add_row(logic [cte_pkg::CMD_W-1:0] cmd, logic [cte_pkg::SLOT_W-1:0] slot,
                         logic [cte_pkg::KIND_W-1:0] kind,
                         logic [cte_pkg::RIGHTS_W-1:0] rights,
                         logic [cte_pkg::OBJ_W-1:0] obj, bit fixed,
                         logic [cte_pkg::STATUS_W-1:0] st,
                         logic [cte_pkg::SLOTO_W-1:0] slot_out,
                         logic [cte_pkg::OBJ_W-1:0] obj_out);
    dir_row_t row;
    row.cmd.command = cmd;
    row.cmd.slot    = slot;
    row.cmd.kind    = kind;
    row.cmd.rights  = rights;
    row.cmd.obj     = obj;
    row.fixed       = fixed;
    row.want.status = st;
    row.want.slot   = slot_out;
    row.want.obj    = obj_out;
    dir_rows.push_back(row);
  endtask

  task automatic send_cap_command(cap_cmd_t c, bit fixed, cap_result_t want, bit may_idle);
    if (may_idle && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= c.command;
    in_slot          <= c.slot;
    in_entry_type    <= c.kind;
    in_rights        <= c.rights;
    in_object_handle <= c.obj;
    row_fixed        <= fixed;
    row_want         <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic cap_cmd_t random_command(bit grow);
    cap_cmd_t c;
    int roll;
    int used[$];
    logic [cte_pkg::RIGHTS_W-1:0] held;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 45) c.command = cte_pkg::CMD_INSERT;
      else if (roll < 70) c.command = cte_pkg::CMD_DERIVE;
      else if (roll < 90) c.command = cte_pkg::CMD_LOOKUP;
      else c.command = cte_pkg::CMD_REVOKE;
    end else begin
      if (roll < 12) c.command = cte_pkg::CMD_INSERT;
      else if (roll < 27) c.command = cte_pkg::CMD_DERIVE;
      else if (roll < 50) c.command = cte_pkg::CMD_LOOKUP;
      else c.command = cte_pkg::CMD_REVOKE;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (kind_tbl[i] != '0) used.push_back(i);
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      c.slot = cte_pkg::SLOT_W'($urandom_range(255, NUM_SLOTS));
    end else if (roll < 20 || used.size() == 0) begin
      c.slot = cte_pkg::SLOT_W'($urandom_range(NUM_SLOTS - 1, 0));
    end else begin
      c.slot = cte_pkg::SLOT_W'(used[$urandom_range(used.size() - 1)]);
    end
    held = (int'(c.slot) < NUM_SLOTS) ? rights_tbl[int'(c.slot)]
                                      : cte_pkg::RIGHTS_W'($urandom);
    roll = $urandom_range(99);
    if (c.command == cte_pkg::CMD_INSERT) begin
      if (roll < 5) c.rights = '1;
      else if (roll < 10) c.rights = '0;
      else c.rights = $urandom;
    end else begin
      if (roll < 65) c.rights = held & cte_pkg::RIGHTS_W'($urandom);
      else if (roll < 75) c.rights = '0;
      else if (roll < 80) c.rights = held;
      else c.rights = $urandom;
    end
    roll = $urandom_range(99);
    if (roll < 6) c.kind = '0;
    else if (roll < 10) c.kind = '1;
    else c.kind = cte_pkg::KIND_W'($urandom_range(65535, 1));
    roll = $urandom_range(99);
    if (roll < 8) c.obj = '0;
    else if (roll < 12) c.obj = '1;
    else c.obj = {$urandom, $urandom};
    return c;
  endfunction

  initial begin
    cap_cmd_t    c;
    cap_result_t none;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = cte_pkg::CMD_INSERT;
    in_slot          = '0;
    in_entry_type    = '0;
    in_rights        = '0;
    in_object_handle = '0;
    row_fixed        = 1'b0;
    none.status      = cte_pkg::ST_OK;
    none.slot        = '0;
    none.obj         = '0;
    row_want         = none;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      kind_tbl[i]   = '0;
      rights_tbl[i] = '0;
      obj_tbl[i]    = '0;
    end

    add_row(cte_pkg::CMD_LOOKUP, 8'd0,   16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_FREE,    6'd0, 64'h0);
    add_row(cte_pkg::CMD_REVOKE, 8'd63,  16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_FREE,    6'd0, 64'h0);
    add_row(cte_pkg::CMD_DERIVE, 8'd255, 16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_INVALID, 6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd64,  16'h0000, 32'hFFFF_FFFF, 64'h0, 1,
            cte_pkg::ST_INVALID, 6'd0, 64'h0);
    add_row(cte_pkg::CMD_INSERT, 8'd0,   16'hFFFF, 32'hFFFF_FFFF, '1,    1,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_INSERT, 8'd9,   16'h0000, 32'h0000_0000, 64'h1234, 1,
            cte_pkg::ST_OK,      6'd1, 64'h0);
    add_row(cte_pkg::CMD_INSERT, 8'd200, 16'h0001, 32'h0000_00F0, 64'h0, 1,
            cte_pkg::ST_OK,      6'd1, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd0,   16'h0000, 32'hFFFF_FFFF, 64'h0, 1,
            cte_pkg::ST_OK,      6'd0, '1);
    add_row(cte_pkg::CMD_LOOKUP, 8'd1,   16'h0000, 32'h0000_0010, 64'h0, 1,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd1,   16'h0000, 32'h0000_0001, 64'h0, 1,
            cte_pkg::ST_DENIED,  6'd0, 64'h0);
    add_row(cte_pkg::CMD_DERIVE, 8'd1,   16'h0000, 32'h0000_000F, 64'h0, 1,
            cte_pkg::ST_DENIED,  6'd0, 64'h0);
    add_row(cte_pkg::CMD_DERIVE, 8'd0,   16'h0000, 32'hA5A5_A5A5, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_DERIVE, 8'd2,   16'h0000, 32'h0000_0000, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd2,   16'h0000, 32'h5A5A_5A5A, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_REVOKE, 8'd1,   16'hFFFF, 32'hFFFF_FFFF, '1,    1,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd1,   16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_FREE,    6'd0, 64'h0);
    add_row(cte_pkg::CMD_DERIVE, 8'd3,   16'h0000, 32'h0000_0000, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd3,   16'h0000, 32'h0000_0000, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_INSERT, 8'd0,   16'h8000, 32'h8000_0000, 64'h8000_0000_0000_0000, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd4,   16'h0000, 32'h8000_0000, 64'h0, 0,
            cte_pkg::ST_OK,      6'd0, 64'h0);
    add_row(cte_pkg::CMD_REVOKE, 8'd255, 16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_INVALID, 6'd0, 64'h0);
    add_row(cte_pkg::CMD_LOOKUP, 8'd128, 16'h0000, 32'h0000_0000, 64'h0, 1,
            cte_pkg::ST_INVALID, 6'd0, 64'h0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_cap_command(dir_rows[i].cmd, dir_rows[i].fixed,
                                           dir_rows[i].want, 1'b1);
    wait_drained();

    for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        c = random_command(seg % 2 == 0);
        send_cap_command(c, 1'b0, none, seg != 2);
      end
      wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d results): ok %0d, invalid slot %0d, table full %0d,",
             accepted_count, result_count, status_seen[cte_pkg::ST_OK],
             status_seen[cte_pkg::ST_INVALID], status_seen[cte_pkg::ST_FULL]);
    $display("  slot free %0d, rights denied %0d; %0d mismatches",
             status_seen[cte_pkg::ST_FREE], status_seen[cte_pkg::ST_DENIED], error_count);
    if (error_count == 0) begin
      $display("tb_capability_table_engine_top: PASS");
    end else begin
      $display("tb_capability_table_engine_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/cte_pkg.sv
src/cte_ram.sv
src/cte_free_enc.sv
src/capability_table_engine_top.sv
sim/tb_capability_table_engine_top.sv
